@@ sv/mdt_pkg.sv @@
// ----------------------------------------------------------------------------
// mdt_pkg
// Types and constants shared by the dead-zone test drive modules.
// ----------------------------------------------------------------------------
package mdt_pkg;

  localparam int unsigned POS_W   = 32;
  localparam int unsigned CMD_W   = 16;
  localparam int unsigned PWM_W   = 16;
  localparam int unsigned LIM_W   = 15;
  localparam int unsigned BAND_W  = 31;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned CFG_W   = 31;
  localparam int unsigned ODATA_W = 72;

  localparam logic signed [CMD_W-1:0] CMD_MAX = 16'sd32767;
  localparam logic signed [CMD_W-1:0] CMD_MIN = -16'sd32767;

  // Register indexes on the configuration channel
  localparam logic [IDX_W-1:0] REG_DZ_FWD    = 3'd0;
  localparam logic [IDX_W-1:0] REG_DZ_BWD    = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAX_PWM   = 3'd2;
  localparam logic [IDX_W-1:0] REG_RAMP_LIM  = 3'd3;
  localparam logic [IDX_W-1:0] REG_STOP_BAND = 3'd4;

  // Register reset values
  localparam logic [PWM_W-1:0]  DZ_FWD_RST    = 16'd1130;
  localparam logic [PWM_W-1:0]  DZ_BWD_RST    = 16'd1200;
  localparam logic [PWM_W-1:0]  MAX_PWM_RST   = 16'd5000;
  localparam logic [LIM_W-1:0]  RAMP_LIM_RST  = 15'd60;
  localparam logic [BAND_W-1:0] STOP_BAND_RST = 31'd325;

  // Test sequencer phases
  typedef enum logic [3:0] {
    PH_FWD_RAMP = 4'b0001,
    PH_FWD_WAIT = 4'b0010,
    PH_BWD_RAMP = 4'b0100,
    PH_BWD_WAIT = 4'b1000
  } phase_t;

  localparam logic [PHASE_W-1:0] PCODE_FWD_RAMP = 2'd0;
  localparam logic [PHASE_W-1:0] PCODE_FWD_WAIT = 2'd1;
  localparam logic [PHASE_W-1:0] PCODE_BWD_RAMP = 2'd2;
  localparam logic [PHASE_W-1:0] PCODE_BWD_WAIT = 2'd3;

  typedef struct packed {
    logic [PWM_W-1:0]  dz_fwd;
    logic [PWM_W-1:0]  dz_bwd;
    logic [PWM_W-1:0]  max_pwm;
    logic [LIM_W-1:0]  ramp_lim;
    logic [BAND_W-1:0] stop_band;
  } cfg_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] command;
    logic [PHASE_W-1:0]      phase;
    logic signed [POS_W-1:0] speed;
  } seq_t;

  typedef struct packed {
    logic [PWM_W-1:0] pwm;
    logic             in1;
    logic             in2;
  } drive_t;

  function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
    logic [PHASE_W-1:0] code;
    unique case (ph)
      PH_FWD_RAMP: code = PCODE_FWD_RAMP;
      PH_FWD_WAIT: code = PCODE_FWD_WAIT;
      PH_BWD_RAMP: code = PCODE_BWD_RAMP;
      PH_BWD_WAIT: code = PCODE_BWD_WAIT;
      default:     code = PCODE_FWD_RAMP;
    endcase
    return code;
  endfunction

endpackage

@@ sv/motor_deadzone_test_drive.sv @@
// ----------------------------------------------------------------------------
// motor_deadzone_test_drive
// Dead-zone test drive for a DC motor behind an H-bridge.
// ----------------------------------------------------------------------------
// One encoder sample per transaction, one result per transaction. A sample
// sits in the input register, is processed combinationally into the result
// register and from there appears on the master side. A new sample is taken
// every cycle while results drain; when a result waits on m_tready, one more
// sample is taken into the input register and s_tready then stays low until
// the result leaves. The throughput of one per cycle rests on the previous
// count, phase and command registers updating on each advance. Configuration
// writes are taken at once (cfg_ready is always high) and belong between runs.
// ----------------------------------------------------------------------------
module motor_deadzone_test_drive import mdt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [POS_W-1:0]   s_tdata,  // [31:0] position_count
  output logic               m_tvalid,
  input  logic               m_tready,
  // [15:0] pwm_compare, [16] drive_in1, [17] drive_in2, [33:18] command_value,
  // [35:34] test_phase, [67:36] speed_counts, [71:68] zero
  output logic [ODATA_W-1:0] m_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  cfg_t             cfg;
  logic             in_valid;
  logic [POS_W-1:0] in_pos;
  logic             advance;
  seq_t             seq;
  drive_t           drive;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dz_fwd    <= DZ_FWD_RST;
      cfg.dz_bwd    <= DZ_BWD_RST;
      cfg.max_pwm   <= MAX_PWM_RST;
      cfg.ramp_lim  <= RAMP_LIM_RST;
      cfg.stop_band <= STOP_BAND_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DZ_FWD:    cfg.dz_fwd    <= cfg_data[PWM_W-1:0];
        REG_DZ_BWD:    cfg.dz_bwd    <= cfg_data[PWM_W-1:0];
        REG_MAX_PWM:   cfg.max_pwm   <= cfg_data[PWM_W-1:0];
        REG_RAMP_LIM:  cfg.ramp_lim  <= cfg_data[LIM_W-1:0];
        REG_STOP_BAND: cfg.stop_band <= cfg_data[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample moves to the result register when that is empty or being drained
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_pos <= s_tdata;
    end
  end

  mdt_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .position (in_pos),
    .cfg      (cfg),
    .seq      (seq)
  );

  mdt_compensate u_comp (
    .command (seq.command),
    .cfg     (cfg),
    .drive   (drive)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {4'b0000, seq.speed, seq.phase, seq.command,
                  drive.in2, drive.in1, drive.pwm};
    end
  end

endmodule

@@ sv/mdt_sequencer.sv @@
// ----------------------------------------------------------------------------
// mdt_sequencer
// Speed from the encoder count difference, and the four-phase ramp/wait
// sequencer holding the test command. State moves on each advance.
// ----------------------------------------------------------------------------
module mdt_sequencer import mdt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [POS_W-1:0] position,
  input  cfg_t             cfg,
  output seq_t             seq
);

  logic [POS_W-1:0]        previous_count;
  phase_t                  phase;
  phase_t                  phase_next;
  logic signed [CMD_W-1:0] command;
  logic signed [CMD_W-1:0] command_next;

  logic [POS_W-1:0]        diff;
  logic [POS_W-1:0]        speed_mag;
  logic                    stopped;
  logic signed [CMD_W-1:0] cmd_up;
  logic signed [CMD_W-1:0] cmd_down;
  logic signed [CMD_W:0]   lim_pos;
  logic signed [CMD_W:0]   lim_neg;

  assign diff      = position - previous_count;
  assign speed_mag = diff[POS_W-1] ? (~diff + 1'b1) : diff;
  assign stopped   = (speed_mag <= {1'b0, cfg.stop_band});

  assign cmd_up   = (command < CMD_MAX) ? command + 16'sd1 : command;
  assign cmd_down = (command > CMD_MIN) ? command - 16'sd1 : command;
  assign lim_pos  = $signed({2'b00, cfg.ramp_lim});
  assign lim_neg  = -lim_pos;

  always_comb begin
    phase_next   = phase;
    command_next = '0;
    unique case (phase)
      PH_FWD_RAMP: begin
        if ($signed({cmd_up[CMD_W-1], cmd_up}) > lim_pos) begin
          phase_next = PH_FWD_WAIT;
        end else begin
          command_next = cmd_up;
        end
      end
      PH_FWD_WAIT: begin
        if (stopped) phase_next = PH_BWD_RAMP;
      end
      PH_BWD_RAMP: begin
        if ($signed({cmd_down[CMD_W-1], cmd_down}) < lim_neg) begin
          phase_next = PH_BWD_WAIT;
        end else begin
          command_next = cmd_down;
        end
      end
      PH_BWD_WAIT: begin
        if (stopped) phase_next = PH_FWD_RAMP;
      end
      default: phase_next = PH_FWD_RAMP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_count <= '0;
      phase          <= PH_FWD_RAMP;
      command        <= '0;
    end else if (advance) begin
      previous_count <= position;
      phase          <= phase_next;
      command        <= command_next;
    end
  end

  assign seq.command = command_next;
  assign seq.phase   = phase_code(phase_next);
  assign seq.speed   = $signed(diff);

endmodule

@@ sv/mdt_compensate.sv @@
// ----------------------------------------------------------------------------
// mdt_compensate
// Dead-zone offset by direction, saturation to max_pwm, H-bridge pins.
// ----------------------------------------------------------------------------
module mdt_compensate import mdt_pkg::*; (
  input  logic signed [CMD_W-1:0] command,
  input  cfg_t                    cfg,
  output drive_t                  drive
);

  logic [CMD_W-2:0] cmd_mag;
  logic [PWM_W-1:0] offset;
  logic [PWM_W:0]   sum;
  logic             is_neg;
  logic             is_pos;

  assign is_neg  = command[CMD_W-1];
  assign is_pos  = !is_neg && (command != '0);
  assign cmd_mag = is_neg ? (CMD_W-1)'(-command) : command[CMD_W-2:0];
  assign offset  = is_neg ? cfg.dz_bwd : cfg.dz_fwd;
  assign sum     = {2'b00, cmd_mag} + {1'b0, offset};

  always_comb begin
    drive.in1 = is_pos;
    drive.in2 = is_neg;
    if (!is_pos && !is_neg) begin
      drive.pwm = '0;
    end else if (sum > {1'b0, cfg.max_pwm}) begin
      drive.pwm = cfg.max_pwm;
    end else begin
      drive.pwm = sum[PWM_W-1:0];
    end
  end

endmodule

@@ dv/motor_deadzone_test_drive_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_deadzone_test_drive_tb
// Self-checking bench for the dead-zone test drive: encoder samples go in on
// the slave stream. An in-bench copy of the sequencer, speed and dead-zone
// logic forms the expected drive word for every sample. Drive words leaving
// the master stream are checked field by field and in order. Runs a short
// table of samples, then random traffic over several register settings, then
// a short ramp in each direction under a full-scale ramp limit, then a last random run.
// ----------------------------------------------------------------------------
module motor_deadzone_test_drive_tb;
  import mdt_pkg::*;

  localparam int DIR_ROWS     = 20;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int SWEEP_ITEMS  = 20;

  typedef struct packed {
    logic [PWM_W-1:0]        pwm;
    logic                    in1;
    logic                    in2;
    logic signed [CMD_W-1:0] cmd;
    logic [PHASE_W-1:0]      phase;
    logic signed [POS_W-1:0] speed;
  } drive_result_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             typed;
    drive_result_t    want;
  } dir_row_t;

  localparam drive_result_t NO_RES = '0;

  logic               clk = 1'b0;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [POS_W-1:0]   s_tdata;    // [31:0] position_count
  logic               m_tvalid;
  logic               m_tready;
  // [15:0] pwm_compare, [16] drive_in1, [17] drive_in2, [33:18] command_value,
  // [35:34] test_phase, [67:36] speed_counts, [71:68] zero
  logic [ODATA_W-1:0] m_tdata;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  // register mirror
  logic [PWM_W-1:0]  offs_fwd;
  logic [PWM_W-1:0]  offs_bwd;
  logic [PWM_W-1:0]  pwm_ceiling;
  logic [LIM_W-1:0]  ramp_end;
  logic [BAND_W-1:0] still_band;

  // sequencer state
  logic [POS_W-1:0]   last_pos;
  logic [PHASE_W-1:0] seq_phase;
  int                 ramp_cmd;

  drive_result_t pending_drive[$];
  drive_result_t want_res;
  int            error_count = 0;
  int            cycle_count = 0;
  bit            gaps_on = 1'b1;
  bit            stall_request = 1'b0;

  // samples at reset settings; first three have hand-worked results
  dir_row_t dir_table [DIR_ROWS] = '{
    '{32'h0000_0000, 1'b1, '{16'd1131, 1'b1, 1'b0, 16'sd1, PCODE_FWD_RAMP, 32'sd0}},
    '{32'hFFFF_FFFF, 1'b1, '{16'd1132, 1'b1, 1'b0, 16'sd2, PCODE_FWD_RAMP, -32'sd1}},
    '{32'h8000_0000, 1'b1,
      '{16'd1133, 1'b1, 1'b0, 16'sd3, PCODE_FWD_RAMP, 32'sh8000_0001}},
    '{32'h0000_0000, 1'b0, NO_RES},
    '{32'h7FFF_FFFF, 1'b0, NO_RES},
    '{32'h8000_0000, 1'b0, NO_RES},
    '{32'h7FFF_FFFF, 1'b0, NO_RES},
    '{32'hFFFF_FFFF, 1'b0, NO_RES},
    '{32'h0000_0001, 1'b0, NO_RES},
    '{32'h5555_5555, 1'b0, NO_RES},
    '{32'hAAAA_AAAA, 1'b0, NO_RES},
    '{32'hAAAA_AAAA, 1'b0, NO_RES},
    '{32'hAAAA_ABEF, 1'b0, NO_RES},
    '{32'hAAAA_AAAA, 1'b0, NO_RES},
    '{32'hAAAA_ABF0, 1'b0, NO_RES},
    '{32'h0000_FFFF, 1'b0, NO_RES},
    '{32'hFFFF_0000, 1'b0, NO_RES},
    '{32'h1234_5678, 1'b0, NO_RES},
    '{32'h1234_5678, 1'b0, NO_RES},
    '{32'h0000_0000, 1'b0, NO_RES}
  };

  motor_deadzone_test_drive dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // one control tick: speed, sequencer update, dead-zone offset and clamp
  function automatic drive_result_t step_drive(input logic [POS_W-1:0] pos);
    drive_result_t res;
    logic [POS_W-1:0] diff;
    logic [POS_W-1:0] speed_mag;
    logic stopped;
    int lim;
    int mag;
    diff      = pos - last_pos;
    last_pos  = pos;
    speed_mag = diff[POS_W-1] ? (32'd0 - diff) : diff;
    stopped   = (speed_mag <= {1'b0, still_band});
    lim       = int'(ramp_end);
    case (seq_phase)
      PCODE_FWD_RAMP: begin
        if (ramp_cmd < int'(CMD_MAX)) ramp_cmd = ramp_cmd + 1;
        if (ramp_cmd > lim) begin
          ramp_cmd  = 0;
          seq_phase = PCODE_FWD_WAIT;
        end
      end
      PCODE_FWD_WAIT: begin
        ramp_cmd = 0;
        if (stopped) seq_phase = PCODE_BWD_RAMP;
      end
      PCODE_BWD_RAMP: begin
        if (ramp_cmd > int'(CMD_MIN)) ramp_cmd = ramp_cmd - 1;
        if (ramp_cmd < -lim) begin
          ramp_cmd  = 0;
          seq_phase = PCODE_BWD_WAIT;
        end
      end
      default: begin
        ramp_cmd = 0;
        if (stopped) seq_phase = PCODE_FWD_RAMP;
      end
    endcase
    res = NO_RES;
    if (ramp_cmd < 0) begin
      mag     = -ramp_cmd + int'(offs_bwd);
      res.pwm = (mag > int'(pwm_ceiling)) ? pwm_ceiling : PWM_W'(mag);
      res.in2 = 1'b1;
    end else if (ramp_cmd > 0) begin
      mag     = ramp_cmd + int'(offs_fwd);
      res.pwm = (mag > int'(pwm_ceiling)) ? pwm_ceiling : PWM_W'(mag);
      res.in1 = 1'b1;
    end
    res.cmd   = CMD_W'(ramp_cmd);
    res.phase = seq_phase;
    res.speed = diff;
    return res;
  endfunction

  // mostly small moves so the stop waits get through, with jumps and edges
  function automatic logic [POS_W-1:0] next_position(input logic [POS_W-1:0] from);
    logic [POS_W-1:0] k;
    logic [POS_W-1:0] step;
    logic [POS_W-1:0] pos;
    int pick;
    pick = $urandom_range(0, 99);
    k    = (still_band > 31'd400) ? 32'd400 : {1'b0, still_band};
    step = 32'd0;
    if (pick < 55) begin
      step = $urandom_range(0, 2 * k) - k;
    end else if (pick < 70) begin
      step = k + 32'd1 + $urandom_range(0, 5000);
    end else if (pick >= 92) begin
      step = {1'b0, still_band} + $urandom_range(0, 1);
    end
    if ($urandom_range(0, 1) == 1) step = 32'd0 - step;
    pos = from + step;
    if (pick >= 70 && pick < 85) begin
      pos = $urandom;
    end else if (pick >= 85 && pick < 92) begin
      case ($urandom_range(0, 3))
        0:       pos = 32'h0000_0000;
        1:       pos = 32'hFFFF_FFFF;
        2:       pos = 32'h8000_0000;
        default: pos = 32'h7FFF_FFFF;
      endcase
    end
    return pos;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  // called on a falling edge, returns on a falling edge with s_tvalid low
  task automatic send_position(input logic [POS_W-1:0] pos, input bit fixed = 1'b0,
                               input drive_result_t fixed_res = NO_RES);
    drive_result_t res;
    if (gaps_on && $urandom_range(0, 99) < 27) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = pos;
    do @(posedge clk); while (!s_tready);
    res = step_drive(pos);
    pending_drive.push_back(fixed ? fixed_res : res);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // writes every index, the unused ones with junk that must be ignored
  task automatic load_settings(input logic [CFG_W-1:0] dzf, input logic [CFG_W-1:0] dzb,
                               input logic [CFG_W-1:0] maxp, input logic [CFG_W-1:0] lim,
                               input logic [CFG_W-1:0] band);
    logic [CFG_W-1:0] word;
    for (int i = 0; i < (1 << IDX_W); i++) begin
      case (IDX_W'(i))
        REG_DZ_FWD:    word = dzf;
        REG_DZ_BWD:    word = dzb;
        REG_MAX_PWM:   word = maxp;
        REG_RAMP_LIM:  word = lim;
        REG_STOP_BAND: word = band;
        default:       word = CFG_W'($urandom);
      endcase
      cfg_valid = 1'b1;
      cfg_index = IDX_W'(i);
      cfg_data  = word;
      do @(posedge clk); while (!cfg_ready);
      case (cfg_index)
        REG_DZ_FWD:    offs_fwd    = cfg_data[PWM_W-1:0];
        REG_DZ_BWD:    offs_bwd    = cfg_data[PWM_W-1:0];
        REG_MAX_PWM:   pwm_ceiling = cfg_data[PWM_W-1:0];
        REG_RAMP_LIM:  ramp_end    = cfg_data[LIM_W-1:0];
        REG_STOP_BAND: still_band  = cfg_data[BAND_W-1:0];
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  task automatic settle_outputs();
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_run(input int count);
    repeat (count) send_position(next_position(last_pos));
  endtask

  // receiver: random back-pressure, plus one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        m_tready = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
      end
      m_tready = !(gaps_on && $urandom_range(0, 99) < 21);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_drive.size() == 0) begin
        report_mismatch($sformatf("drive word %h with nothing pending", m_tdata));
      end else begin
        want_res = pending_drive.pop_front();
        if (m_tdata[15:0] !== want_res.pwm)
          report_mismatch($sformatf("pwm_compare %0d, want %0d", m_tdata[15:0], want_res.pwm));
        if (m_tdata[16] !== want_res.in1)
          report_mismatch($sformatf("drive_in1 %b, want %b", m_tdata[16], want_res.in1));
        if (m_tdata[17] !== want_res.in2)
          report_mismatch($sformatf("drive_in2 %b, want %b", m_tdata[17], want_res.in2));
        if (m_tdata[33:18] !== want_res.cmd)
          report_mismatch($sformatf("command_value %0d, want %0d",
                                    $signed(m_tdata[33:18]), want_res.cmd));
        if (m_tdata[35:34] !== want_res.phase)
          report_mismatch($sformatf("test_phase %0d, want %0d", m_tdata[35:34], want_res.phase));
        if (m_tdata[67:36] !== want_res.speed)
          report_mismatch($sformatf("speed_counts %0d, want %0d",
                                    $signed(m_tdata[67:36]), want_res.speed));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;

    offs_fwd    = DZ_FWD_RST;
    offs_bwd    = DZ_BWD_RST;
    pwm_ceiling = MAX_PWM_RST;
    ramp_end    = RAMP_LIM_RST;
    still_band  = STOP_BAND_RST;
    last_pos    = '0;
    seq_phase   = PCODE_FWD_RAMP;
    ramp_cmd    = 0;

    repeat (8) @(negedge clk);
    rst = 1'b0;

    for (int r = 0; r < DIR_ROWS; r++)
      send_position(dir_table[r].pos, dir_table[r].typed, dir_table[r].want);

    // reset settings, with the output held off long enough to back up the input
    stall_request = 1'b1;
    random_run(200);

    // low extremes: no offsets, ramp ends after one step, only a dead stop counts
    settle_outputs();
    load_settings(31'd0, 31'd0, 31'd65535, 31'd0, 31'd0);
    random_run(110);

    // high extremes: offset sums beyond 16 bits, everything short of half scale stops
    settle_outputs();
    load_settings(31'd65535, 31'd65535, 31'd65535, 31'd5, 31'h7FFF_FFFF);
    random_run(110);

    // zero ceiling: compare stays zero while the pins follow direction
    settle_outputs();
    load_settings(31'd1130, 31'd1200, 31'd0, 31'd10, 31'd100);
    random_run(110);

    for (int s = 0; s < 6; s++) begin
      settle_outputs();
      load_settings(CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)),
                    ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 65535))
                                                : CFG_W'($urandom_range(800, 3000)),
                    CFG_W'($urandom_range(0, 25)),
                    ($urandom_range(0, 3) == 0) ? CFG_W'($urandom & 32'h7FFF_FFFF)
                                                : CFG_W'($urandom_range(0, 1000)));
      random_run(80);
    end

    settle_outputs();
    gaps_on = 1'b0;
    load_settings(31'd300, 31'd700, 31'd1500, 31'd12, 31'd325);
    random_run(80);

    // full-scale ramp limit: walk to the forward ramp, then ramp with no end in reach
    settle_outputs();
    load_settings(31'd40000, 31'd40000, 31'd65535, 31'd3, 31'd1000);
    while (seq_phase != PCODE_FWD_RAMP) send_position(next_position(last_pos));
    settle_outputs();
    load_settings(31'd40000, 31'd40000, 31'd65535, 31'h7FFF, 31'd1000);
    random_run(SWEEP_ITEMS);

    // a small limit ends that ramp; walk on to the backward ramp and do the same
    settle_outputs();
    load_settings(31'd40000, 31'd40000, 31'd65535, 31'd3, 31'd1000);
    while (seq_phase != PCODE_BWD_RAMP) send_position(next_position(last_pos));
    settle_outputs();
    load_settings(31'd40000, 31'd40000, 31'd65535, 31'h7FFF, 31'd1000);
    random_run(SWEEP_ITEMS);

    settle_outputs();
    gaps_on = 1'b1;
    load_settings(31'd1130, 31'd1200, 31'd5000, 31'd0, 31'd325);
    random_run(20);

    s_tvalid = 1'b0;
    settle_outputs();
    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

@@ motor_deadzone_test_drive.f @@
sv/mdt_pkg.sv
sv/mdt_sequencer.sv
sv/mdt_compensate.sv
sv/motor_deadzone_test_drive.sv
dv/motor_deadzone_test_drive_tb.sv
